[design/at_command_modem_init_sequencer_defines.svh]
// Assertion macros shared by the modem init sequencer RTL.
`ifndef AT_COMMAND_MODEM_INIT_SEQUENCER_DEFINES_SVH
`define AT_COMMAND_MODEM_INIT_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define AMIS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AMIS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AMIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AMIS_ASSERT_ALWAYS(label, cond, msg)
`define AMIS_ASSERT_IMPLY(label, ante, cons, msg)
`define AMIS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[design/amis_pkg.sv]
// Types, constants and command tables of the modem init sequencer.
package amis_pkg;

    // Configuration register width and reset value.
    localparam int CFG_W = 17;
    localparam logic [CFG_W-1:0] RETRY_RESET = 17'h10000;

    // Width of the reported queue count.
    localparam int QCNT_W = 10;

    // Line terminators.
    localparam logic [7:0] CHR_CR  = 8'h0D;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_NUL = 8'h00;

    // Init stages, encoded as reported on the result channel.
    typedef enum logic [2:0] {
        STG_NONE,
        STG_ECHO_SEND,
        STG_ECHO_SENT,
        STG_CLOSE_SEND,
        STG_CLOSE_SENT,
        STG_OPEN_SEND,
        STG_OPEN_SENT,
        STG_DONE
    } stage_t;

    // Command strings held in ROM.
    typedef enum logic [1:0] {
        CMD_SLEEP,
        CMD_ECHO,
        CMD_CLOSE,
        CMD_OPEN
    } cmd_t;

    localparam int SEG_LEN_W = 6;

    // One queued piece of a command: the first len bytes of the command, CR included.
    typedef struct packed {
        cmd_t                 cmd;
        logic [SEG_LEN_W-1:0] len;
    } seg_t;

    // Classified step passed from the line parser to the executor.
    typedef struct packed {
        logic got_ok;
        logic got_error;
        logic tx_ready;
    } evt_t;

    // Input item payload.
    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } item_t;

    // Result item payload.
    typedef struct packed {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic [2:0]        init_stage;
        logic              got_ok;
        logic              got_error;
        logic [QCNT_W-1:0] queue_count;
    } result_t;

    // Command lengths including the trailing CR.
    localparam int SLEEP_N = 11;
    localparam int ECHO_N  = 5;
    localparam int CLOSE_N = 13;
    localparam int OPEN_N  = 43;

    localparam logic [8*SLEEP_N-1:0] SLEEP_STR = {"AT+QSCLK=0", CHR_CR};
    localparam logic [8*ECHO_N-1:0]  ECHO_STR  = {"ATE1", CHR_CR};
    localparam logic [8*CLOSE_N-1:0] CLOSE_STR = {"AT+QICLOSE=0", CHR_CR};
    localparam logic [8*OPEN_N-1:0]  OPEN_STR  =
        {"AT+QIOPEN=1,0,\"UDP\",\"52.4.", "126.47\",1973,0,1", CHR_CR};

    // Reply words.
    localparam int OK_N  = 2;
    localparam int ERR_N = 5;
    localparam logic [8*OK_N-1:0]  OK_STR  = "OK";
    localparam logic [8*ERR_N-1:0] ERR_STR = "ERROR";

    // Length of a command including CR.
    function automatic logic [SEG_LEN_W-1:0] cmd_len(cmd_t cmd);
        logic [SEG_LEN_W-1:0] n;
        case (cmd)
            CMD_SLEEP: n = SEG_LEN_W'(SLEEP_N);
            CMD_ECHO:  n = SEG_LEN_W'(ECHO_N);
            CMD_CLOSE: n = SEG_LEN_W'(CLOSE_N);
            CMD_OPEN:  n = SEG_LEN_W'(OPEN_N);
            default:   n = SEG_LEN_W'(SLEEP_N);
        endcase
        return n;
    endfunction

    // Byte idx of a command; the position past the text is CR.
    function automatic logic [7:0] cmd_char(cmd_t cmd, logic [SEG_LEN_W-1:0] idx);
        logic [7:0] ch;
        ch = CHR_CR;
        case (cmd)
            CMD_SLEEP:
                if (idx < SEG_LEN_W'(SLEEP_N))
                    ch = SLEEP_STR[8*(SLEEP_N-1-int'(idx)) +: 8];
            CMD_ECHO:
                if (idx < SEG_LEN_W'(ECHO_N))
                    ch = ECHO_STR[8*(ECHO_N-1-int'(idx)) +: 8];
            CMD_CLOSE:
                if (idx < SEG_LEN_W'(CLOSE_N))
                    ch = CLOSE_STR[8*(CLOSE_N-1-int'(idx)) +: 8];
            CMD_OPEN:
                if (idx < SEG_LEN_W'(OPEN_N))
                    ch = OPEN_STR[8*(OPEN_N-1-int'(idx)) +: 8];
            default:
                ch = CHR_CR;
        endcase
        return ch;
    endfunction

    // Character idx of the word OK.
    function automatic logic [7:0] ok_char(logic idx);
        return OK_STR[8*(OK_N-1-int'(idx)) +: 8];
    endfunction

    // Character idx of the word ERROR; zero past its end.
    function automatic logic [7:0] err_char(logic [2:0] idx);
        logic [7:0] ch;
        ch = CHR_NUL;
        if (idx < 3'(ERR_N))
            ch = ERR_STR[8*(ERR_N-1-int'(idx)) +: 8];
        return ch;
    endfunction

endpackage

[design/amis_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
interface amis_item_if;
    logic                valid;
    logic                ready;
    amis_pkg::item_t     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface amis_result_if;
    logic                valid;
    logic                ready;
    amis_pkg::result_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/amis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module amis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/amis_front.sv]
// Front end: accepts items and matches received lines against OK and ERROR.
`include "at_command_modem_init_sequencer_defines.svh"

module amis_front #(
    parameter int LINE_DEPTH = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    amis_item_if.sink       item,
    input  logic            q_ready,
    output logic            evt_push,
    output amis_pkg::evt_t  evt
);

    localparam int LW = $clog2(LINE_DEPTH + 1);

    logic [LW-1:0] len_reg, len_next;
    logic          ok_m_reg, ok_m_next;
    logic          err_m_reg, err_m_next;
    logic [7:0]    c;
    logic          accept;
    logic          is_end;
    logic          room;
    logic          ok_hit;
    logic          err_hit;

    // An item is taken whenever the queue has a free slot.
    assign item.ready = q_ready;
    assign accept     = item.valid && q_ready;
    assign evt_push   = accept;

    // Classify the received byte against the line state.
    always_comb
    begin
        c       = item.payload.rx_byte;
        is_end  = (c == amis_pkg::CHR_CR) || (c == amis_pkg::CHR_LF) ||
                  (c == amis_pkg::CHR_NUL);
        room    = len_reg < LW'(LINE_DEPTH);
        ok_hit  = (len_reg < LW'(amis_pkg::OK_N)) &&
                  (c == amis_pkg::ok_char(len_reg[0]));
        err_hit = (len_reg < LW'(amis_pkg::ERR_N)) &&
                  (c == amis_pkg::err_char(len_reg[2:0]));

        evt.got_ok    = item.payload.rx_valid && room && is_end && ok_m_reg &&
                        (len_reg == LW'(amis_pkg::OK_N));
        evt.got_error = item.payload.rx_valid && room && is_end && err_m_reg &&
                        (len_reg == LW'(amis_pkg::ERR_N));
        evt.tx_ready  = item.payload.tx_ready;
    end

    // Line buffer bookkeeping: length and running word matches.
    always_comb
    begin
        len_next   = len_reg;
        ok_m_next  = ok_m_reg;
        err_m_next = err_m_reg;
        if (accept && item.payload.rx_valid)
        begin
            if (room)
            begin
                if (!is_end)
                begin
                    ok_m_next  = ok_m_reg && ok_hit;
                    err_m_next = err_m_reg && err_hit;
                end
                len_next = len_reg + LW'(1);
            end
            if (is_end)
            begin
                len_next   = '0;
                ok_m_next  = 1'b1;
                err_m_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ok_m_reg  <= 1'b1;
            err_m_reg <= 1'b1;
        end
        else
        begin
            len_reg   <= len_next;
            ok_m_reg  <= ok_m_next;
            err_m_reg <= err_m_next;
        end
    end

    // The line length saturates at the buffer size.
    `AMIS_ASSERT_ALWAYS(a_line_bound, len_reg <= LW'(LINE_DEPTH), "line length overran buffer")

endmodule

[design/amis_queue.sv]
// Two-entry queue of classified steps between the front end and the executor.
`include "at_command_modem_init_sequencer_defines.svh"

module amis_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  amis_pkg::evt_t  din,
    output logic            in_ready,
    input  logic            pop,
    output logic            out_valid,
    output amis_pkg::evt_t  dout
);

    amis_pkg::evt_t slot0_reg, slot0_next;
    amis_pkg::evt_t slot1_reg, slot1_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign dout      = slot0_reg;

    // Slot 0 is always the oldest entry.
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        case ({push, pop})
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    slot0_next = din;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = din;
                end
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    slot0_next = din;
                end
                else
                begin
                    slot1_next = din;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Occupancy never exceeds the two slots, and only a filled queue is popped.
    `AMIS_ASSERT_ALWAYS(a_queue_bound, cnt_reg <= 2'd2, "queue occupancy out of range")
    `AMIS_ASSERT_IMPLY(a_pop_nonempty, pop, cnt_reg != 2'd0, "pop from empty queue")

endmodule

[design/amis_back.sv]
// Executor: init stage machine, retry timer, transmit ring and result register.
`include "at_command_modem_init_sequencer_defines.svh"

module amis_back #(
    parameter int TX_DEPTH = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [amis_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        evt_valid,
    input  amis_pkg::evt_t              evt,
    output logic                        evt_pop,
    amis_result_if.source               result
);

    localparam int PW = $clog2(TX_DEPTH);
    localparam int CW = $clog2(TX_DEPTH + 1);
    localparam int MW = (CW > amis_pkg::SEG_LEN_W) ? CW : amis_pkg::SEG_LEN_W;
    localparam int SW = $bits(amis_pkg::seg_t);
    localparam int LW = amis_pkg::SEG_LEN_W;

    // Configuration and stage machine state.
    logic [amis_pkg::CFG_W-1:0] retry_reg;
    amis_pkg::stage_t           stage_reg, stage_next;
    logic [amis_pkg::CFG_W-1:0] wait_reg, wait_next;

    // Ring bookkeeping: bytes, pending segments, pointers and the head segment.
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   seg_cnt_reg, seg_cnt_next;
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic            hv_reg, hv_next;
    logic [LW-1:0]   off_reg, off_next;
    logic            byp_vld_reg, byp_vld_next;
    amis_pkg::seg_t  byp_seg_reg, byp_seg_next;

    // Result register.
    logic              res_vld_reg, res_vld_next;
    amis_pkg::result_t res_reg, res_next;

    // Step-level signals.
    logic                       step;
    logic                       push_en;
    amis_pkg::cmd_t             push_cmd;
    amis_pkg::stage_t           stage_mid;
    logic [amis_pkg::CFG_W-1:0] wait_mid;
    logic [amis_pkg::CFG_W-1:0] wait_inc;
    amis_pkg::seg_t             head_seg;
    amis_pkg::seg_t             push_seg;
    logic [SW-1:0]              ram_rdata;
    logic                       pop;
    logic                       last;
    logic [7:0]                 tx_byte;
    logic [CW-1:0]              cnt_pop;
    logic [MW-1:0]              free_w;
    logic [LW-1:0]              full_len;
    logic [LW-1:0]              push_len;
    logic                       push_do;
    logic                       need;
    logic                       load;
    logic                       from_byp;
    logic                       ram_re;

    // A step runs when an event waits and the result register is free.
    assign step    = evt_valid && (!res_vld_reg || result.ready);
    assign evt_pop = step;

    // Stage machine: reply handling, then the retry timer and command choice.
    always_comb
    begin
        stage_mid  = stage_reg;
        wait_mid   = wait_reg;
        stage_next = stage_reg;
        wait_next  = wait_reg;
        wait_inc   = wait_reg;
        push_en    = 1'b0;
        push_cmd   = amis_pkg::CMD_SLEEP;
        if (step)
        begin
            if (evt.got_ok)
            begin
                case (stage_reg)
                    amis_pkg::STG_NONE:
                    begin
                        stage_mid = amis_pkg::STG_ECHO_SEND;
                        wait_mid  = '0;
                    end
                    amis_pkg::STG_ECHO_SENT:
                    begin
                        stage_mid = amis_pkg::STG_CLOSE_SEND;
                        wait_mid  = '0;
                    end
                    amis_pkg::STG_CLOSE_SENT:
                    begin
                        stage_mid = amis_pkg::STG_OPEN_SEND;
                        wait_mid  = '0;
                    end
                    amis_pkg::STG_OPEN_SENT:
                    begin
                        stage_mid = amis_pkg::STG_DONE;
                    end
                    default:
                    begin
                        stage_mid = stage_reg;
                    end
                endcase
            end
            else if (evt.got_error && (stage_reg == amis_pkg::STG_OPEN_SENT))
            begin
                stage_mid = amis_pkg::STG_OPEN_SEND;
                wait_mid  = '0;
            end

            stage_next = stage_mid;
            wait_next  = wait_mid;
            if (stage_mid != amis_pkg::STG_DONE)
            begin
                wait_inc = wait_mid + amis_pkg::CFG_W'(1);
                if (wait_inc >= retry_reg)
                begin
                    wait_next = '0;
                    case (stage_mid)
                        amis_pkg::STG_NONE:
                        begin
                            push_en  = 1'b1;
                            push_cmd = amis_pkg::CMD_SLEEP;
                        end
                        amis_pkg::STG_ECHO_SEND:
                        begin
                            push_en    = 1'b1;
                            push_cmd   = amis_pkg::CMD_ECHO;
                            stage_next = amis_pkg::STG_ECHO_SENT;
                        end
                        amis_pkg::STG_CLOSE_SEND:
                        begin
                            push_en    = 1'b1;
                            push_cmd   = amis_pkg::CMD_CLOSE;
                            stage_next = amis_pkg::STG_CLOSE_SENT;
                        end
                        amis_pkg::STG_OPEN_SEND:
                        begin
                            push_en    = 1'b1;
                            push_cmd   = amis_pkg::CMD_OPEN;
                            stage_next = amis_pkg::STG_OPEN_SENT;
                        end
                        default:
                        begin
                            push_en = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    wait_next = wait_inc;
                end
            end
        end
    end

    // Head of the ring: the segment just bypassed or the one read from RAM.
    assign head_seg = byp_vld_reg ? byp_seg_reg : amis_pkg::seg_t'(ram_rdata);
    assign pop      = step && hv_reg && evt.tx_ready;
    assign tx_byte  = amis_pkg::cmd_char(head_seg.cmd, off_reg);
    assign last     = (off_reg + LW'(1)) == head_seg.len;
    assign cnt_pop  = cnt_reg - CW'(pop);

    // Command bytes beyond the free space are dropped.
    always_comb
    begin
        full_len = amis_pkg::cmd_len(push_cmd);
        free_w   = MW'(TX_DEPTH) - MW'(cnt_pop);
        push_len = (free_w < MW'(full_len)) ? LW'(free_w) : full_len;
        push_do  = push_en && (push_len != '0);
        push_seg = '{cmd: push_cmd, len: push_len};
    end

    // Segment queue control: refill the head when it drains.
    always_comb
    begin
        need         = !hv_reg || (pop && last);
        from_byp     = seg_cnt_reg == '0;
        load         = step && need && (!from_byp || push_do);
        ram_re       = load && !from_byp;

        cnt_next     = cnt_pop + CW'(push_len & {LW{push_do}});
        seg_cnt_next = seg_cnt_reg + CW'(push_do) - CW'(load);
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        hv_next      = hv_reg;
        off_next     = off_reg;
        byp_vld_next = byp_vld_reg;
        byp_seg_next = byp_seg_reg;

        if (push_do)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(TX_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (load)
        begin
            rd_ptr_next  = (rd_ptr_reg == PW'(TX_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            hv_next      = 1'b1;
            off_next     = '0;
            byp_vld_next = from_byp;
            byp_seg_next = push_seg;
        end
        else if (step && need)
        begin
            hv_next = 1'b0;
        end
        else if (pop)
        begin
            off_next = off_reg + LW'(1);
        end
    end

    amis_ram #(
        .WIDTH (SW),
        .DEPTH (TX_DEPTH)
    ) u_seg_ram (
        .clk   (clk),
        .we    (push_do),
        .waddr (wr_ptr_reg),
        .wdata (push_seg),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Result register: loaded on a step, cleared when the transfer completes.
    always_comb
    begin
        res_next             = res_reg;
        res_vld_next         = res_vld_reg;
        if (step)
        begin
            res_next.tx_valid    = pop;
            res_next.tx_byte     = pop ? tx_byte : 8'h00;
            res_next.init_stage  = stage_next;
            res_next.got_ok      = evt.got_ok;
            res_next.got_error   = evt.got_error;
            res_next.queue_count = amis_pkg::QCNT_W'(cnt_next);
            res_vld_next         = 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_next = 1'b0;
        end
    end

    assign result.valid   = res_vld_reg;
    assign result.payload = res_reg;

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        byp_seg_reg <= byp_seg_next;
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= amis_pkg::STG_NONE;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_reg   <= amis_pkg::RETRY_RESET;
            wait_reg    <= '0;
            cnt_reg     <= '0;
            seg_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            hv_reg      <= 1'b0;
            off_reg     <= '0;
            byp_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                retry_reg <= cfg_data;
            end
            wait_reg    <= wait_next;
            cnt_reg     <= cnt_next;
            seg_cnt_reg <= seg_cnt_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            hv_reg      <= hv_next;
            off_reg     <= off_next;
            byp_vld_reg <= byp_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // A head segment exists exactly when the ring holds bytes.
    `AMIS_ASSERT_ALWAYS(a_head_tracks_count, hv_reg == (cnt_reg != '0), "head valid disagrees with byte count")
    // Segments wait in RAM only behind a valid head.
    `AMIS_ASSERT_IMPLY(a_pending_needs_head, seg_cnt_reg != '0, hv_reg, "segments queued without head")
    // Once done, the stage machine stays done.
    `AMIS_ASSERT_NEXT(a_done_is_final, stage_reg == amis_pkg::STG_DONE, stage_reg == amis_pkg::STG_DONE, "left done stage")

endmodule

[design/at_command_modem_init_sequencer.sv]
// Top level of the AT command modem init sequencer.
//
// Each transfer on the item channel is one service step: an optional received
// modem byte, plus whether the serial transmitter can take a byte. Each step
// yields exactly one transfer on the result channel carrying the byte sent
// (if any), the init stage, the OK/ERROR line flags and the ring fill level.
// The retry period is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Throughput is one step per cycle while the result receiver does not stall.
// An accepted step passes through the event queue and is then loaded into
// the result register, from which it transfers on the result channel.
// The transmit ring stores command segments (command and length) in a RAM of
// TX_DEPTH entries rather than bytes, so a whole command is queued as one segment;
// one byte leaves per cycle from the command ROM while steps run and tx is ready.
// Reset empties the ring and the line buffer, sets the stage to none and the
// retry period to 65536; no clearing pass is needed.
// When the result receiver stalls, the result holds, the queue takes at most
// two more steps, and the item channel's ready then drops until it drains.
module at_command_modem_init_sequencer #(
    parameter int TX_DEPTH   = 512,
    parameter int LINE_DEPTH = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [amis_pkg::CFG_W-1:0] cfg_data,
    amis_item_if.sink                  item,
    amis_result_if.source              result
);

    amis_pkg::evt_t front_evt;
    amis_pkg::evt_t back_evt;
    logic           evt_push;
    logic           q_ready;
    logic           evt_valid;
    logic           evt_pop;

    // Line parser and classifier.
    amis_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .q_ready  (q_ready),
        .evt_push (evt_push),
        .evt      (front_evt)
    );

    // Decoupling queue.
    amis_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (evt_push),
        .din       (front_evt),
        .in_ready  (q_ready),
        .pop       (evt_pop),
        .out_valid (evt_valid),
        .dout      (back_evt)
    );

    // Stage machine, transmit ring and result register.
    amis_back #(
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .evt_valid (evt_valid),
        .evt       (back_evt),
        .evt_pop   (evt_pop),
        .result    (result)
    );

endmodule
